/* hdl/tht_pkg.sv */
// ----------------------------------------------------------------------------
// tht_pkg: shared types and constants
// Field widths, operation and status codes, slot entry layout and the
// controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package tht_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;

  localparam int OP_W     = 3;
  localparam int HANDLE_W = 6;
  localparam int KIND_W   = 4;
  localparam int REF_W    = 32;
  localparam int CODE_W   = 8;
  localparam int STATUS_W = 2;

  localparam int CMP_W = (CNT_W > HANDLE_W) ? CNT_W : HANDLE_W;

  localparam logic [OP_W-1:0] OP_ALLOC      = 3'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP     = 3'd1;
  localparam logic [OP_W-1:0] OP_FREE       = 3'd2;
  localparam logic [OP_W-1:0] OP_FREE_KIND  = 3'd3;
  localparam logic [OP_W-1:0] OP_FREE_TABLE = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DEAD       = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL       = 2'd3;

  typedef struct packed {
    logic              free;
    logic [KIND_W-1:0] kind;
    logic [CODE_W-1:0] code;
    logic [REF_W-1:0]  obj_ref;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic accept;
    logic exec;
    logic walk_rd;
    logic walk_ev;
    logic walk_end;
  } ctrl_cmd_t;

  typedef struct packed {
    logic walk_done;
  } dp_stat_t;

endpackage

/* hdl/tht_ram.sv */
// ----------------------------------------------------------------------------
// tht_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/tht_ctrl.sv */
// ----------------------------------------------------------------------------
// tht_ctrl: request sequencer
// Steps single operations through the execute state and table walks
// through a read/evaluate loop over the appended slots.
// ----------------------------------------------------------------------------
module tht_ctrl
  import tht_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [OP_W-1:0] in_operation,
  input  dp_stat_t        stat,
  output logic            busy,
  output ctrl_cmd_t       cmd
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_EXEC     = 5'b00010,
    S_WALK_RD  = 5'b00100,
    S_WALK_EV  = 5'b01000,
    S_WALK_END = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   is_walk;

  assign is_walk = (in_operation == OP_FREE_KIND) || (in_operation == OP_FREE_TABLE);

  assign busy         = (state_r != S_IDLE);
  assign cmd.accept   = start && (state_r == S_IDLE);
  assign cmd.exec     = (state_r == S_EXEC);
  assign cmd.walk_rd  = (state_r == S_WALK_RD) && !stat.walk_done;
  assign cmd.walk_ev  = (state_r == S_WALK_EV);
  assign cmd.walk_end = (state_r == S_WALK_END);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = is_walk ? S_WALK_RD : S_EXEC;
        end
      end
      S_EXEC:     state_nxt = S_IDLE;
      S_WALK_RD:  state_nxt = stat.walk_done ? S_WALK_END : S_WALK_EV;
      S_WALK_EV:  state_nxt = S_WALK_RD;
      S_WALK_END: state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hdl/tht_dp.sv */
// ----------------------------------------------------------------------------
// tht_dp: handle table datapath
// Slot memory, free-slot stack memory, counters, request and pending
// release registers, and the result register.
// ----------------------------------------------------------------------------
module tht_dp
  import tht_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  ctrl_cmd_t           cmd,
  output dp_stat_t            stat,
  input  logic [OP_W-1:0]     in_operation,
  input  logic [HANDLE_W-1:0] in_handle,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [REF_W-1:0]    in_object_ref,
  input  logic [CODE_W-1:0]   in_release_code,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [HANDLE_W-1:0] out_result_handle,
  output logic [REF_W-1:0]    out_result_ref,
  output logic [CODE_W-1:0]   out_result_code,
  output logic                out_released,
  output logic                out_last
);

  function automatic logic [HANDLE_W-1:0] handle_of(input logic [IDX_W-1:0] idx);
    handle_of = HANDLE_W'(CNT_W'(idx) + CNT_W'(1));
  endfunction

  // latched request
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [HANDLE_W-1:0] handle_r, handle_nxt;
  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic [REF_W-1:0]    ref_r, ref_nxt;
  logic [CODE_W-1:0]   code_r, code_nxt;

  // table bookkeeping
  logic [CNT_W-1:0]    slots_r, slots_nxt;
  logic [CNT_W-1:0]    free_depth_r, free_depth_nxt;
  logic [CNT_W-1:0]    wlk_r, wlk_nxt;

  // release held back until it is known whether another one follows
  logic                pend_vld_r, pend_vld_nxt;
  logic [HANDLE_W-1:0] pend_handle_r, pend_handle_nxt;
  logic [REF_W-1:0]    pend_ref_r, pend_ref_nxt;
  logic [CODE_W-1:0]   pend_code_r, pend_code_nxt;

  // result register
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [HANDLE_W-1:0] out_handle_r;
  logic [REF_W-1:0]    out_ref_r;
  logic [CODE_W-1:0]   out_code_r;
  logic                out_rel_r;
  logic                out_last_r;

  logic                emit;
  logic [STATUS_W-1:0] o_status;
  logic [HANDLE_W-1:0] o_handle;
  logic [REF_W-1:0]    o_ref;
  logic [CODE_W-1:0]   o_code;
  logic                o_rel;
  logic                o_last;

  // memory ports
  logic               ent_we, ent_re;
  logic [IDX_W-1:0]   ent_waddr, ent_raddr;
  logic [ENTRY_W-1:0] ent_wdata, ent_rdata;
  logic               stk_we, stk_re;
  logic [IDX_W-1:0]   stk_waddr, stk_raddr, stk_wdata, stk_rdata;

  entry_t           ent_rd, rel_ent, new_ent;
  logic [IDX_W-1:0] hit_idx, wlk_idx, alloc_idx;
  logic             stk_room, bad_handle, match;

  assign ent_rd    = entry_t'(ent_rdata);
  assign hit_idx   = IDX_W'(handle_r - HANDLE_W'(1));
  assign wlk_idx   = wlk_r[IDX_W-1:0];
  assign stk_room  = free_depth_r < CNT_W'(TABLE_DEPTH);
  assign bad_handle = (handle_r == '0) || (CMP_W'(handle_r) > CMP_W'(slots_r));
  assign match     = !ent_rd.free && ((op_r == OP_FREE_TABLE) || (ent_rd.kind == kind_r));

  assign rel_ent = '{free: 1'b1, kind: ent_rd.kind, code: ent_rd.code, obj_ref: '0};
  assign new_ent = '{free: 1'b0, kind: kind_r, code: code_r, obj_ref: ref_r};

  assign stat.walk_done = (wlk_r == slots_r);

  // reads are issued at accept so execute sees the data in the following cycle
  assign ent_re    = cmd.accept || cmd.walk_rd;
  assign ent_raddr = cmd.walk_rd ? wlk_idx : IDX_W'(in_handle - HANDLE_W'(1));
  assign stk_re    = cmd.accept;
  assign stk_raddr = IDX_W'(free_depth_r - CNT_W'(1));

  always_comb begin
    op_nxt          = op_r;
    handle_nxt      = handle_r;
    kind_nxt        = kind_r;
    ref_nxt         = ref_r;
    code_nxt        = code_r;
    slots_nxt       = slots_r;
    free_depth_nxt  = free_depth_r;
    wlk_nxt         = wlk_r;
    pend_vld_nxt    = pend_vld_r;
    pend_handle_nxt = pend_handle_r;
    pend_ref_nxt    = pend_ref_r;
    pend_code_nxt   = pend_code_r;
    alloc_idx       = slots_r[IDX_W-1:0];
    ent_we          = 1'b0;
    ent_waddr       = hit_idx;
    ent_wdata       = '0;
    stk_we          = 1'b0;
    stk_waddr       = free_depth_r[IDX_W-1:0];
    stk_wdata       = hit_idx;
    emit            = 1'b0;
    o_status        = ST_OK;
    o_handle        = '0;
    o_ref           = '0;
    o_code          = '0;
    o_rel           = 1'b0;
    o_last          = 1'b0;

    if (cmd.accept) begin
      op_nxt       = in_operation;
      handle_nxt   = in_handle;
      kind_nxt     = in_kind;
      ref_nxt      = in_object_ref;
      code_nxt     = in_release_code;
      wlk_nxt      = '0;
      pend_vld_nxt = 1'b0;
    end

    if (cmd.exec) begin
      emit   = 1'b1;
      o_last = 1'b1;
      unique case (op_r)
        OP_ALLOC: begin
          priority if (free_depth_r != '0) begin
            alloc_idx      = stk_rdata;
            free_depth_nxt = free_depth_r - CNT_W'(1);
          end else if (slots_r != CNT_W'(TABLE_DEPTH)) begin
            alloc_idx = slots_r[IDX_W-1:0];
            slots_nxt = slots_r + CNT_W'(1);
          end else begin
            o_status = ST_FULL;
          end
          if (o_status == ST_OK) begin
            ent_we    = 1'b1;
            ent_waddr = alloc_idx;
            ent_wdata = new_ent;
            o_handle  = handle_of(alloc_idx);
          end
        end
        OP_LOOKUP, OP_FREE: begin
          priority if (bad_handle) begin
            o_status = ST_BAD_HANDLE;
          end else if (ent_rd.free || ((op_r == OP_LOOKUP) && (ent_rd.kind != kind_r))) begin
            o_status = ST_DEAD;
          end else if (op_r == OP_LOOKUP) begin
            o_ref = ent_rd.obj_ref;
          end else begin
            ent_we    = 1'b1;
            ent_wdata = rel_ent;
            if (stk_room) begin
              stk_we         = 1'b1;
              free_depth_nxt = free_depth_r + CNT_W'(1);
            end
            o_handle = handle_of(hit_idx);
            o_ref    = ent_rd.obj_ref;
            o_code   = ent_rd.code;
            o_rel    = 1'b1;
          end
        end
        default: begin
          o_status = ST_OK;
        end
      endcase
    end

    if (cmd.walk_ev) begin
      wlk_nxt = wlk_r + CNT_W'(1);
      if (match) begin
        ent_we    = 1'b1;
        ent_waddr = wlk_idx;
        ent_wdata = rel_ent;
        stk_wdata = wlk_idx;
        if (stk_room) begin
          stk_we         = 1'b1;
          free_depth_nxt = free_depth_r + CNT_W'(1);
        end
        if (pend_vld_r) begin
          emit     = 1'b1;
          o_handle = pend_handle_r;
          o_ref    = pend_ref_r;
          o_code   = pend_code_r;
          o_rel    = 1'b1;
        end
        pend_vld_nxt    = 1'b1;
        pend_handle_nxt = handle_of(wlk_idx);
        pend_ref_nxt    = ent_rd.obj_ref;
        pend_code_nxt   = ent_rd.code;
      end
    end

    if (cmd.walk_end) begin
      emit         = 1'b1;
      o_last       = 1'b1;
      pend_vld_nxt = 1'b0;
      if (pend_vld_r) begin
        o_handle = pend_handle_r;
        o_ref    = pend_ref_r;
        o_code   = pend_code_r;
        o_rel    = 1'b1;
      end
      if (op_r == OP_FREE_TABLE) begin
        slots_nxt      = '0;
        free_depth_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r      <= '0;
      free_depth_r <= '0;
      wlk_r        <= '0;
      pend_vld_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      slots_r      <= slots_nxt;
      free_depth_r <= free_depth_nxt;
      wlk_r        <= wlk_nxt;
      pend_vld_r   <= pend_vld_nxt;
      out_valid_r  <= emit;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    handle_r      <= handle_nxt;
    kind_r        <= kind_nxt;
    ref_r         <= ref_nxt;
    code_r        <= code_nxt;
    pend_handle_r <= pend_handle_nxt;
    pend_ref_r    <= pend_ref_nxt;
    pend_code_r   <= pend_code_nxt;
    if (emit) begin
      out_status_r <= o_status;
      out_handle_r <= o_handle;
      out_ref_r    <= o_ref;
      out_code_r   <= o_code;
      out_rel_r    <= o_rel;
      out_last_r   <= o_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_result_handle = out_handle_r;
  assign out_result_ref    = out_ref_r;
  assign out_result_code   = out_code_r;
  assign out_released      = out_rel_r;
  assign out_last          = out_last_r;

  tht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .re    (ent_re),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  tht_ram #(
    .WIDTH (IDX_W),
    .DEPTH (TABLE_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // every stacked slot was appended once and freed once
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_depth_r <= slots_r)
    else $error("free stack deeper than appended slots");

  a_slots_bound: assert property (@(posedge clk) disable iff (!rst_n)
    slots_r <= CNT_W'(TABLE_DEPTH))
    else $error("slot count beyond table depth");

  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid_r && out_last_r)
    else $error("single operation gave no final result");

  a_walk_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_end |=> out_valid_r && out_last_r && !pend_vld_r)
    else $error("table walk ended without final result");

endmodule

/* hdl/typed_handle_table_allocator.sv */
// ----------------------------------------------------------------------------
// typed_handle_table_allocator: typed handle table with free-slot stack
// Allocate, lookup, free, free-all-of-kind and free-whole-table over a
// table of TABLE_DEPTH slots.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Allocate, lookup,
// free and unknown operations keep busy high through the execute state after
// the accept, since the slot and stack memories have registered reads; their
// single result is strobed on out_valid in the cycle after the execute state.
// Free-all-of-kind and free-whole-table walk the appended slots through the
// single read port of the slot memory, a read state and an evaluate state per
// slot, with busy high until the end state; each release is strobed as it
// is confirmed and out_last marks the final result. Results are strobed for one
// cycle and must be taken: there is no back-pressure. No clearing pass runs
// after reset.
module typed_handle_table_allocator
  import tht_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     in_operation,
  input  logic [HANDLE_W-1:0] in_handle,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [REF_W-1:0]    in_object_ref,
  input  logic [CODE_W-1:0]   in_release_code,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [HANDLE_W-1:0] out_result_handle,
  output logic [REF_W-1:0]    out_result_ref,
  output logic [CODE_W-1:0]   out_result_code,
  output logic                out_released,
  output logic                out_last
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  tht_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .stat         (stat),
    .busy         (busy),
    .cmd          (cmd)
  );

  tht_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_operation      (in_operation),
    .in_handle         (in_handle),
    .in_kind           (in_kind),
    .in_object_ref     (in_object_ref),
    .in_release_code   (in_release_code),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_result_handle (out_result_handle),
    .out_result_ref    (out_result_ref),
    .out_result_code   (out_result_code),
    .out_released      (out_released),
    .out_last          (out_last)
  );

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench for typed_handle_table_allocator
// Drives allocate, lookup, free and the two table walks through the
// start/busy port with random gaps, keeps its own copy of the slot table and
// free stack to predict every result, and compares each strobed result
// field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
  import tht_pkg::*;

  localparam logic [OP_W-1:0] OP_RSVD_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_HI = 3'd7;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] hdl;
    logic [REF_W-1:0]    obj_ref;
    logic [CODE_W-1:0]   code;
    logic                released;
    logic                is_last;
  } table_result_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [OP_W-1:0]     in_operation;
  logic [HANDLE_W-1:0] in_handle;
  logic [KIND_W-1:0]   in_kind;
  logic [REF_W-1:0]    in_object_ref;
  logic [CODE_W-1:0]   in_release_code;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [HANDLE_W-1:0] out_result_handle;
  logic [REF_W-1:0]    out_result_ref;
  logic [CODE_W-1:0]   out_result_code;
  logic                out_released;
  logic                out_last;

  // Predicted copy of the slot table and free stack
  logic [REF_W-1:0]    tbl_ref  [TABLE_DEPTH];
  logic [KIND_W-1:0]   tbl_kind [TABLE_DEPTH];
  logic [CODE_W-1:0]   tbl_code [TABLE_DEPTH];
  bit                  tbl_free [TABLE_DEPTH];
  int                  free_stk [TABLE_DEPTH];
  int                  free_cnt = 0;
  int                  tbl_used = 0;

  table_result_t       pending_results[$];
  table_result_t       want;
  int                  mismatch_count = 0;
  int                  burst_left = 0;

  typed_handle_table_allocator DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_handle         (in_handle),
    .in_kind           (in_kind),
    .in_object_ref     (in_object_ref),
    .in_release_code   (in_release_code),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_result_handle (out_result_handle),
    .out_result_ref    (out_result_ref),
    .out_result_code   (out_result_code),
    .out_released      (out_released),
    .out_last          (out_last)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic void queue_result(logic [STATUS_W-1:0] st, int hdl,
                                       logic [REF_W-1:0] oref,
                                       logic [CODE_W-1:0] code, bit rel, bit lst);
    table_result_t r;
    r.status   = st;
    r.hdl      = hdl[HANDLE_W-1:0];
    r.obj_ref  = oref;
    r.code     = code;
    r.released = rel;
    r.is_last  = lst;
    pending_results.push_back(r);
  endfunction

  function automatic void release_slot(int idx);
    queue_result(ST_OK, idx + 1, tbl_ref[idx], tbl_code[idx], 1'b1, 1'b0);
    tbl_ref[idx]  = '0;
    tbl_free[idx] = 1'b1;
    if (free_cnt < TABLE_DEPTH) begin
      free_stk[free_cnt] = idx;
      free_cnt++;
    end
  endfunction

  function automatic void mark_final();
    pending_results[pending_results.size() - 1].is_last = 1'b1;
  endfunction

  // Works out the results of one accepted request and updates the table copy
  function automatic void model_request(logic [OP_W-1:0] op, logic [HANDLE_W-1:0] h,
                                        logic [KIND_W-1:0] k, logic [REF_W-1:0] oref,
                                        logic [CODE_W-1:0] rcode);
    int idx;
    int n_rel;
    idx   = -1;
    n_rel = 0;
    case (op)
      OP_ALLOC: begin
        if (free_cnt > 0) begin
          free_cnt--;
          idx = free_stk[free_cnt];
        end else if (tbl_used < TABLE_DEPTH) begin
          idx = tbl_used;
          tbl_used++;
        end
        if (idx < 0) begin
          queue_result(ST_FULL, 0, '0, '0, 1'b0, 1'b1);
        end else begin
          tbl_ref[idx]  = oref;
          tbl_kind[idx] = k;
          tbl_code[idx] = rcode;
          tbl_free[idx] = 1'b0;
          queue_result(ST_OK, idx + 1, '0, '0, 1'b0, 1'b1);
        end
      end
      OP_LOOKUP, OP_FREE: begin
        idx = int'(h) - 1;
        if (h == 0 || int'(h) > tbl_used) begin
          queue_result(ST_BAD_HANDLE, 0, '0, '0, 1'b0, 1'b1);
        end else if (tbl_free[idx] || (op == OP_LOOKUP && tbl_kind[idx] != k)) begin
          queue_result(ST_DEAD, 0, '0, '0, 1'b0, 1'b1);
        end else if (op == OP_LOOKUP) begin
          queue_result(ST_OK, 0, tbl_ref[idx], '0, 1'b0, 1'b1);
        end else begin
          release_slot(idx);
          mark_final();
        end
      end
      OP_FREE_KIND, OP_FREE_TABLE: begin
        for (int i = 0; i < tbl_used; i++) begin
          if (!tbl_free[i] && (op == OP_FREE_TABLE || tbl_kind[i] == k)) begin
            release_slot(i);
            n_rel++;
          end
        end
        if (op == OP_FREE_TABLE) begin
          tbl_used = 0;
          free_cnt = 0;
        end
        if (n_rel == 0) queue_result(ST_OK, 0, '0, '0, 1'b0, 1'b1);
        else mark_final();
      end
      default: queue_result(ST_OK, 0, '0, '0, 1'b0, 1'b1);
    endcase
  endfunction

  // Drive one request and hold it until the block takes it
  task automatic send_request(logic [OP_W-1:0] op, logic [HANDLE_W-1:0] h,
                              logic [KIND_W-1:0] k, logic [REF_W-1:0] oref,
                              logic [CODE_W-1:0] rcode);
    int gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = $urandom_range(18);
      if ($urandom_range(7) == 0) burst_left = $urandom_range(20, 8);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_operation    <= op;
    in_handle       <= h;
    in_kind         <= k;
    in_object_ref   <= oref;
    in_release_code <= rcode;
    // busy is stable at the falling edge; low there means the next edge takes it
    do @(negedge clk); while (busy);
    @(posedge clk);
    model_request(op, h, k, oref, rcode);
  endtask

  task automatic req_alloc(logic [KIND_W-1:0] k, logic [REF_W-1:0] oref,
                           logic [CODE_W-1:0] rcode);
    send_request(OP_ALLOC, HANDLE_W'($urandom_range(32)), k, oref, rcode);
  endtask

  task automatic req_lookup(logic [HANDLE_W-1:0] h, logic [KIND_W-1:0] k);
    send_request(OP_LOOKUP, h, k, $urandom, CODE_W'($urandom_range(255)));
  endtask

  task automatic req_free(logic [HANDLE_W-1:0] h);
    send_request(OP_FREE, h, KIND_W'($urandom_range(15)), $urandom,
                 CODE_W'($urandom_range(255)));
  endtask

  task automatic req_walk(logic [OP_W-1:0] op, logic [KIND_W-1:0] k);
    send_request(op, HANDLE_W'($urandom_range(32)), k, $urandom,
                 CODE_W'($urandom_range(255)));
  endtask

  function automatic int pick_live_slot();
    int cands[$];
    for (int i = 0; i < tbl_used; i++)
      if (!tbl_free[i]) cands.push_back(i);
    if (cands.size() == 0) return -1;
    return cands[$urandom_range(cands.size() - 1)];
  endfunction

  task automatic test_empty_table();
    req_lookup(0, 0);
    req_free(1);
    req_walk(OP_FREE_KIND, 4'hf);
    req_walk(OP_FREE_TABLE, 0);
  endtask

  task automatic test_alloc_lookup_free();
    req_alloc(4'h0, 32'h0000_0000, 8'h00);
    req_alloc(4'hf, 32'hffff_ffff, 8'hff);
    req_alloc(4'h5, $urandom, CODE_W'($urandom_range(255)));
    req_lookup(1, 4'h0);
    req_lookup(2, 4'hf);
    req_lookup(2, 4'he);      // wrong kind
    req_lookup(4, 4'h5);      // above slots in use
    req_free(2);
    req_free(2);              // double free
    req_lookup(2, 4'hf);      // dead slot
    req_alloc(4'ha, $urandom, CODE_W'($urandom_range(255)));  // reuses handle 2
  endtask

  task automatic test_free_walks();
    req_walk(OP_FREE_KIND, 4'h5);
    req_walk(OP_FREE_KIND, 4'h9);   // no match
    for (int op = int'(OP_RSVD_LO); op <= int'(OP_RSVD_HI); op++)
      send_request(op[OP_W-1:0], HANDLE_W'($urandom_range(32)), KIND_W'($urandom_range(15)),
                   $urandom, CODE_W'($urandom_range(255)));
    req_walk(OP_FREE_TABLE, KIND_W'($urandom_range(15)));
  endtask

  task automatic test_table_full();
    logic [KIND_W-1:0] k;
    while (!(tbl_used == TABLE_DEPTH && free_cnt == 0))
      req_alloc(KIND_W'($urandom_range(15)), $urandom, CODE_W'($urandom_range(255)));
    req_alloc(KIND_W'($urandom_range(15)), $urandom, CODE_W'($urandom_range(255)));
    k = tbl_kind[TABLE_DEPTH-1];
    req_lookup(HANDLE_W'(TABLE_DEPTH), k);
    req_free(HANDLE_W'(TABLE_DEPTH));
    req_alloc(k + 4'd1, $urandom, CODE_W'($urandom_range(255)));
    req_lookup(HANDLE_W'(TABLE_DEPTH), k);   // same handle, now another kind
    req_free(0);
    req_walk(OP_FREE_KIND, KIND_W'($urandom_range(15)));
  endtask

  task automatic test_random_mix(int count);
    int pick;
    int slot;
    logic [KIND_W-1:0] k;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      slot = pick_live_slot();
      k    = ($urandom_range(3) == 0) ? KIND_W'($urandom_range(15))
                                      : KIND_W'($urandom_range(3));
      if (pick < 40) begin
        req_alloc(k, $urandom, CODE_W'($urandom_range(255)));
      end else if (pick < 60) begin
        if (slot >= 0 && $urandom_range(3) != 0)
          req_lookup(HANDLE_W'(slot + 1), ($urandom_range(6) == 0) ? k : tbl_kind[slot]);
        else
          req_lookup(HANDLE_W'($urandom_range(32)), k);
      end else if (pick < 80) begin
        if (slot >= 0 && $urandom_range(3) != 0) req_free(HANDLE_W'(slot + 1));
        else req_free(HANDLE_W'($urandom_range(32)));
      end else if (pick < 88) begin
        req_walk(OP_FREE_KIND, k);
      end else if (pick < 91) begin
        req_walk(OP_FREE_TABLE, k);
      end else if (pick < 95) begin
        send_request(OP_W'($urandom_range(OP_RSVD_HI, OP_RSVD_LO)),
                     HANDLE_W'($urandom_range(32)), k, $urandom,
                     CODE_W'($urandom_range(255)));
      end else begin
        // handle zero or past the appended slots
        slot = (tbl_used < TABLE_DEPTH) ? $urandom_range(TABLE_DEPTH, tbl_used + 1) : 0;
        if (pick[0]) req_free(HANDLE_W'(slot));
        else req_lookup(HANDLE_W'(slot), k);
      end
    end
  endtask

  function automatic void check_field(string name, logic [REF_W-1:0] exp_val,
                                      logic [REF_W-1:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, got_val);
      mismatch_count++;
    end
  endfunction

  // Results last one cycle; sample them mid-cycle
  always @(negedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result with no request pending: status %0d handle %0d",
               out_status, out_result_handle);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", REF_W'(want.status), REF_W'(out_status));
        check_field("result_handle", REF_W'(want.hdl), REF_W'(out_result_handle));
        check_field("result_ref", want.obj_ref, out_result_ref);
        check_field("result_code", REF_W'(want.code), REF_W'(out_result_code));
        check_field("released", REF_W'(want.released), REF_W'(out_released));
        check_field("last", REF_W'(want.is_last), REF_W'(out_last));
      end
    end
  end

  initial begin
    #1_000_000;
    $display("tb_top failed");
    $finish;
  end

  initial begin
    int drain;
    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_operation    <= '0;
    in_handle       <= '0;
    in_kind         <= '0;
    in_object_ref   <= '0;
    in_release_code <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_alloc_lookup_free();
    test_free_walks();
    test_table_full();
    test_random_mix(110);

    start <= 1'b0;
    drain = 0;
    while (pending_results.size() != 0 && drain < 2000) begin
      @(posedge clk);
      drain++;
    end
    // a full-table walk can still be running
    repeat (2 * TABLE_DEPTH + 20) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule

/* sim.f */
hdl/tht_pkg.sv
hdl/tht_ram.sv
hdl/tht_ctrl.sv
hdl/tht_dp.sv
hdl/typed_handle_table_allocator.sv
bench/tb_top.sv
